// ----- design/sensor_response_crc_decoder_unit_assert.svh -----
// Assertion macros for the sensor response CRC decoder.
// Included inside module bodies that have clk and arst_n; needs no package.
`ifndef SENSOR_RESPONSE_CRC_DECODER_UNIT_ASSERT_SVH
`define SENSOR_RESPONSE_CRC_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define SRCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ----- design/srcd_pkg.sv -----
// Types, constants and the CRC-8 step for the sensor response decoder.
// No dependencies.
package srcd_pkg;

	typedef enum logic [1:0] {
		KIND_MEAS   = 2'd0,
		KIND_READY  = 2'd1,
		KIND_SELF   = 2'd2,
		KIND_SERIAL = 2'd3
	} kind_t;

	typedef logic [15:0] word_t;

	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [10:0] READY_MASK  = 11'h7FF;
	localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [13:0] HUM_SPAN    = 14'd10000;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SELF   = 3'd4;
	localparam logic [2:0] ST_SERIAL = 3'd5;

	// one byte of CRC-8, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- design/srcd_scale.sv -----
// Converts raw temperature and humidity words to centidegrees and centipercent.
// Uses srcd_pkg; divide by 65535 done as shift plus one correction step.
module srcd_scale (
	input  srcd_pkg::word_t     raw_temp,
	input  srcd_pkg::word_t     raw_hum,
	output logic signed [14:0]  temperature_centi,
	output logic [13:0]         humidity_centi
);
	import srcd_pkg::*;

	logic [30:0] t_prod;
	logic [14:0] t_q0;
	logic [16:0] t_rem;
	logic [14:0] t_quo;
	logic [15:0] t_diff;
	logic [29:0] h_prod;
	logic [13:0] h_q0;
	logic [16:0] h_rem;
	logic [13:0] h_quo;

	// x/65535: q0 = x>>16, remainder x - q0*65535 = lo + q0 < 2*65535
	always_comb begin
		t_prod = 31'(raw_temp) * 31'(TEMP_SPAN);
		t_q0   = t_prod[30:16];
		t_rem  = {1'b0, t_prod[15:0]} + 17'(t_q0);
		t_quo  = t_q0 + 15'(t_rem >= 17'(FULL_SCALE));
		t_diff = {1'b0, t_quo} - TEMP_OFFSET;
		temperature_centi = signed'(t_diff[14:0]);

		h_prod = 30'(raw_hum) * 30'(HUM_SPAN);
		h_q0   = h_prod[29:16];
		h_rem  = {1'b0, h_prod[15:0]} + 17'(h_q0);
		h_quo  = h_q0 + 14'(h_rem >= 17'(FULL_SCALE));
		humidity_centi = h_quo;
	end

endmodule

// ----- design/sensor_response_crc_decoder_unit.sv -----
// Sensor response decoder: groups response bytes into CRC-8 checked words (serial
// unchecked), converts measurements. Uses srcd_pkg, srcd_scale, assertion header.
//
//   channel | direction | handshake            | beat
//   item    | in        | item_valid/item_stall | func, data_byte, first
//   res     | out       | res_valid/res_stall   | status, words, converted values
//
// One byte per cycle sustained while the result side does not stall. A byte lands
// in the input register, then word/CRC tracking and conversion fill the result
// register, which shows the result once its last byte has passed. Reset clears
// kind, position, CRC and words. A stalled result holds both stages; the input
// register frees as soon as its byte moves on.
module sensor_response_crc_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic [7:0]         data_byte,
	input  logic               first,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         status,
	output srcd_pkg::word_t    word_first,
	output srcd_pkg::word_t    word_second,
	output srcd_pkg::word_t    word_third,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               data_ready
);
	import srcd_pkg::*;

	typedef enum logic [2:0] {
		PH_HIGH  = 3'b001,
		PH_LOW   = 3'b010,
		PH_CHECK = 3'b100
	} phase_t;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [7:0]  data_s1;
	logic        first_s1;

	kind_t       kind_q;
	phase_t      phase_q;
	logic [1:0]  widx_q;
	logic [7:0]  high_q;
	logic [7:0]  crc_q;
	logic [2:0]  err_q;
	word_t       words_q [3];

	kind_t       cur_kind;
	phase_t      cur_phase;
	logic [1:0]  cur_widx;
	logic [7:0]  cur_high;
	logic [7:0]  cur_crc;
	logic [2:0]  cur_err;
	word_t       cur_words [3];
	logic [1:0]  nwords;
	logic        active;
	logic        last;

	phase_t      phase_nx;
	logic [1:0]  widx_nx;
	logic [7:0]  high_nx;
	logic [7:0]  crc_nx;
	logic [2:0]  err_nx;
	word_t       words_nx [3];
	logic [2:0]  status_nx;

	logic signed [14:0] temp_cv;
	logic [13:0]        hum_cv;

	logic res_valid_q;
	logic advance;
	logic s1_load;
	logic step;

	assign advance    = !(res_valid_q && res_stall);
	assign s1_load    = !valid_s1 || advance;
	assign item_stall = !s1_load;
	assign step       = valid_s1 && advance;
	assign res_valid  = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && item_valid) begin
			func_s1  <= func;
			data_s1  <= data_byte;
			first_s1 <= first;
		end
	end

	always_comb begin
		cur_kind  = first_s1 ? kind_t'(func_s1) : kind_q;
		cur_phase = first_s1 ? PH_HIGH : phase_q;
		cur_widx  = first_s1 ? 2'd0 : widx_q;
		cur_high  = first_s1 ? 8'd0 : high_q;
		cur_crc   = first_s1 ? CRC_INIT : crc_q;
		cur_err   = first_s1 ? ST_OK : err_q;
		for (int i = 0; i < 3; i++) begin
			cur_words[i] = first_s1 ? 16'd0 : words_q[i];
		end

		nwords = (cur_kind == KIND_MEAS || cur_kind == KIND_SERIAL) ? 2'd3 : 2'd1;
		active = cur_widx < nwords;
		last   = active && (cur_phase == PH_CHECK) && (cur_widx + 2'd1 == nwords);

		phase_nx = cur_phase;
		widx_nx  = cur_widx;
		high_nx  = cur_high;
		crc_nx   = cur_crc;
		err_nx   = cur_err;
		for (int i = 0; i < 3; i++) begin
			words_nx[i] = cur_words[i];
		end

		if (active) begin
			unique case (cur_phase)
				PH_HIGH: begin
					high_nx  = data_s1;
					crc_nx   = crc8_step(CRC_INIT, data_s1);
					phase_nx = PH_LOW;
				end
				PH_LOW: begin
					words_nx[cur_widx] = {cur_high, data_s1};
					crc_nx   = crc8_step(cur_crc, data_s1);
					phase_nx = PH_CHECK;
				end
				default: begin
					if (cur_kind != KIND_SERIAL && cur_crc != data_s1
							&& cur_err == ST_OK) begin
						err_nx = {1'b0, cur_widx} + 3'd1;
					end
					phase_nx = PH_HIGH;
					widx_nx  = cur_widx + 2'd1;
				end
			endcase
		end

		priority if (err_nx != ST_OK) begin
			status_nx = err_nx;
		end else if (cur_kind == KIND_SELF && cur_words[0] != 16'd0) begin
			status_nx = ST_SELF;
		end else if (cur_kind == KIND_SERIAL && cur_words[0] == 16'd0
				&& cur_words[1] == 16'd0 && cur_words[2] == 16'd0) begin
			status_nx = ST_SERIAL;
		end else begin
			status_nx = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_MEAS;
			phase_q <= PH_HIGH;
			widx_q  <= 2'd0;
			high_q  <= 8'd0;
			crc_q   <= CRC_INIT;
			err_q   <= ST_OK;
			for (int i = 0; i < 3; i++) begin
				words_q[i] <= 16'd0;
			end
		end else if (step) begin
			kind_q  <= cur_kind;
			phase_q <= phase_nx;
			widx_q  <= widx_nx;
			high_q  <= high_nx;
			crc_q   <= crc_nx;
			err_q   <= err_nx;
			for (int i = 0; i < 3; i++) begin
				words_q[i] <= words_nx[i];
			end
		end
	end

	// last byte is never marked first, so the stored words are final here
	srcd_scale u_scale (
		.raw_temp          (words_q[1]),
		.raw_hum           (words_q[2]),
		.temperature_centi (temp_cv),
		.humidity_centi    (hum_cv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && last;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) begin
			status            <= status_nx;
			word_first        <= cur_words[0];
			word_second       <= cur_words[1];
			word_third        <= cur_words[2];
			temperature_centi <= (cur_kind == KIND_MEAS) ? temp_cv : 15'sd0;
			humidity_centi    <= (cur_kind == KIND_MEAS) ? hum_cv : 14'd0;
			data_ready        <= (cur_kind == KIND_READY)
				&& (cur_words[0][10:0] & READY_MASK) != 11'd0;
		end
	end

	`include "sensor_response_crc_decoder_unit_assert.svh"

	`SRCD_ASSERT_NOW(a_res_last, $rose(res_valid_q), $past(valid_s1 && last), "stray result")
	`SRCD_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_q), "byte phase not one-hot")
	`SRCD_ASSERT_NOW(a_stall_cause, item_stall, valid_s1 && !advance, "needless input stall")
	`SRCD_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, $stable(data_s1), "held byte lost")

endmodule

// ----- tb/sensor_response_crc_decoder_unit_tb.sv -----
// Testbench for sensor_response_crc_decoder_unit: drives response bytes with random gaps and
// stalls, predicts each decoded result with a local CRC-8/conversion model and compares.
// Depends on srcd_pkg and the unit RTL.
module sensor_response_crc_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srcd_pkg::*;

	typedef struct packed {
		logic [2:0]         status;
		word_t              w0;
		word_t              w1;
		word_t              w2;
		logic signed [14:0] temp;
		logic [13:0]        hum;
		logic               ready;
	} decoded_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [1:0]         func = '0;
	logic [7:0]         data_byte = '0;
	logic               first = 1'b0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [2:0]         status;
	word_t              word_first;
	word_t              word_second;
	word_t              word_third;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;
	logic               data_ready;

	decoded_t expected_results[$];
	int       mismatches = 0;
	int       bytes_sent = 0;
	int       sink_hold = 0;
	int       results_seen = 0;
	int       results_paced = 0;
	bit       source_steady = 1'b0;
	bit       sink_steady = 1'b0;

	// local copy of the decoder state
	kind_t             resp_kind = KIND_MEAS;
	logic [3:0]        resp_pos = '0;
	logic [7:0]        resp_crc = CRC_INIT;
	logic [7:0]        resp_high = '0;
	logic [2:0][15:0]  resp_words = '0;
	logic [2:0]        resp_error = ST_OK;

	sensor_response_crc_decoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.data_byte(data_byte),
		.first(first),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.word_first(word_first),
		.word_second(word_second),
		.word_third(word_third),
		.temperature_centi(temperature_centi),
		.humidity_centi(humidity_centi),
		.data_ready(data_ready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// bit-serial CRC-8, MSB first
	function automatic logic [7:0] crc_update(input logic [7:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic int length_of(input kind_t k);
		return (k == KIND_MEAS || k == KIND_SERIAL) ? 9 : 3;
	endfunction

	task automatic decode_byte(input logic [1:0] f, input logic [7:0] b, input logic mark);
		int       len;
		int       w;
		int       t;
		decoded_t d;
		if (mark) begin
			resp_kind = kind_t'(f);
			resp_pos = '0;
			resp_crc = CRC_INIT;
			resp_high = '0;
			resp_words = '0;
			resp_error = ST_OK;
		end
		len = length_of(resp_kind);
		if (resp_pos >= len) return;
		w = resp_pos / 3;
		case (resp_pos % 3)
		0: begin
			resp_high = b;
			resp_crc = crc_update(CRC_INIT, b);
		end
		1: begin
			resp_words[w] = {resp_high, b};
			resp_crc = crc_update(resp_crc, b);
		end
		default: begin
			if (resp_kind != KIND_SERIAL && resp_crc != b && resp_error == ST_OK)
				resp_error = 3'(w + 1);
		end
		endcase
		resp_pos++;
		if (resp_pos < len) return;

		d.status = resp_error;
		if (d.status == ST_OK) begin
			if (resp_kind == KIND_SELF && resp_words[0] != '0)
				d.status = ST_SELF;
			else if (resp_kind == KIND_SERIAL && resp_words == '0)
				d.status = ST_SERIAL;
		end
		d.w0 = resp_words[0];
		d.w1 = resp_words[1];
		d.w2 = resp_words[2];
		d.temp = '0;
		d.hum = '0;
		d.ready = 1'b0;
		if (resp_kind == KIND_MEAS) begin
			t = int'((32'(TEMP_SPAN) * 32'(resp_words[1])) / 32'(FULL_SCALE)) - int'(TEMP_OFFSET);
			d.temp = 15'(t);
			d.hum = 14'((32'(HUM_SPAN) * 32'(resp_words[2])) / 32'(FULL_SCALE));
		end
		if (resp_kind == KIND_READY)
			d.ready = |(resp_words[0] & 16'(READY_MASK));
		expected_results.push_back(d);
	endtask

	task automatic send_byte(input logic [1:0] f, input logic [7:0] b, input logic mark);
		int gap;
		gap = source_steady ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		func <= f;
		data_byte <= b;
		first <= mark;
		do @(posedge clk); while (item_stall);
		decode_byte(f, b, mark);
		bytes_sent++;
	endtask

	// bad marks which words get a corrupted CRC byte
	task automatic send_response(input kind_t k, input logic [2:0][15:0] wds,
			input logic [2:0] bad, input int nbytes, input logic mark);
		logic [7:0] c;
		logic [7:0] b;
		for (int i = 0; i < nbytes; i++) begin
			case (i % 3)
			0: begin
				b = wds[i / 3][15:8];
			end
			1: begin
				b = wds[i / 3][7:0];
			end
			default: begin
				c = crc_update(crc_update(CRC_INIT, wds[i / 3][15:8]), wds[i / 3][7:0]);
				b = bad[i / 3] ? c ^ 8'($urandom_range(1, 255)) : c;
			end
			endcase
			send_byte(i == 0 ? 2'(k) : 2'($urandom_range(0, 3)), b, i == 0 ? mark : 1'b0);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_headless_after_reset();
		send_response(KIND_MEAS, {16'h8000, 16'h6667, 16'h1234}, 3'b000, 9, 1'b0);
	endtask

	task automatic test_measurement();
		send_response(KIND_MEAS, {16'h0000, 16'h0000, 16'h0000}, 3'b000, 9, 1'b1);
		send_response(KIND_MEAS, {16'hFFFF, 16'hFFFF, 16'hFFFF}, 3'b000, 9, 1'b1);
		send_response(KIND_MEAS, {16'h5A5A, 16'hA5A5, 16'h0400}, 3'b110, 9, 1'b1);
	endtask

	task automatic test_data_ready();
		send_response(KIND_READY, {32'h0, 16'h8000}, 3'b000, 3, 1'b1);
		send_response(KIND_READY, {32'h0, 16'h07FF}, 3'b001, 3, 1'b1);
	endtask

	task automatic test_self_test();
		send_response(KIND_SELF, {32'h0, 16'h0000}, 3'b000, 3, 1'b1);
		send_response(KIND_SELF, {32'h0, 16'h0001}, 3'b000, 3, 1'b1);
		send_response(KIND_SELF, {32'h0, 16'h0001}, 3'b001, 3, 1'b1);
	endtask

	task automatic test_serial_id();
		send_response(KIND_SERIAL, {16'h0000, 16'h0000, 16'h0000}, 3'b111, 9, 1'b1);
		send_response(KIND_SERIAL, {16'h0000, 16'h0001, 16'h0000}, 3'b010, 9, 1'b1);
	endtask

	task automatic test_trailing_and_restart();
		send_response(KIND_READY, {32'h0, 16'h0100}, 3'b000, 3, 1'b1);
		send_byte(2'(KIND_SELF), 8'hFF, 1'b0);
		send_byte(2'(KIND_MEAS), 8'h00, 1'b0);
		send_response(KIND_MEAS, {16'h1111, 16'h2222, 16'h3333}, 3'b000, 5, 1'b1);
		send_response(KIND_SELF, {32'h0, 16'h0000}, 3'b000, 3, 1'b1);
		drain_results();
	endtask

	task automatic test_random_traffic();
		kind_t            k;
		logic [2:0][15:0] wds;
		logic [2:0]       bad;
		int               len;
		int               nbytes;
		int               pick;
		int               stop;
		stop = bytes_sent + 570;
		while (bytes_sent < stop) begin
			if ($urandom_range(0, 15) == 0) source_steady = !source_steady;
			if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
			if ($urandom_range(0, 40) == 0) drain_results();
			k = kind_t'($urandom_range(0, 3));
			for (int j = 0; j < 3; j++) begin
				case ($urandom_range(0, 7))
				0: wds[j] = 16'h0000;
				1: wds[j] = 16'hFFFF;
				default: wds[j] = 16'($urandom);
				endcase
				bad[j] = ($urandom_range(0, 5) == 0);
			end
			if (k == KIND_SELF && $urandom_range(0, 1) == 1) wds[0] = '0;
			if (k == KIND_SERIAL && $urandom_range(0, 5) == 0) wds = '0;
			len = length_of(k);
			pick = $urandom_range(0, 19);
			nbytes = (pick == 0) ? $urandom_range(1, len - 1) : len;
			send_response(k, wds, bad, nbytes, 1'b1);
			if (pick == 1) begin
				repeat ($urandom_range(1, 3))
					send_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'b0);
			end
			if (pick == 2)
				send_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
		end
	endtask

	always @(negedge clk) begin
		if (results_seen != results_paced) begin
			results_paced = results_seen;
			sink_hold = sink_steady ? 0 : $urandom_range(0, 10);
		end
		if (sink_hold > 0) begin
			res_stall <= 1'b1;
			sink_hold--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat, status %0d", status);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (word_first !== want.w0) begin
					$error("word_first: expected %h, got %h", want.w0, word_first);
					mismatches++;
				end
				if (word_second !== want.w1) begin
					$error("word_second: expected %h, got %h", want.w1, word_second);
					mismatches++;
				end
				if (word_third !== want.w2) begin
					$error("word_third: expected %h, got %h", want.w2, word_third);
					mismatches++;
				end
				if (temperature_centi !== want.temp) begin
					$error("temperature_centi: expected %0d, got %0d", want.temp,
						temperature_centi);
					mismatches++;
				end
				if (humidity_centi !== want.hum) begin
					$error("humidity_centi: expected %0d, got %0d", want.hum, humidity_centi);
					mismatches++;
				end
				if (data_ready !== want.ready) begin
					$error("data_ready: expected %0d, got %0d", want.ready, data_ready);
					mismatches++;
				end
			end
			results_seen++;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_headless_after_reset();
		test_measurement();
		test_data_ready();
		test_self_test();
		test_serial_id();
		test_trailing_and_restart();
		test_random_traffic();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
